FILE: hw/rtl/bafb_pkg.sv
package bafb_pkg;

    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_N = 7;

    localparam int unsigned IN_BITS   = 62;
    localparam int unsigned IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int unsigned OUT_BITS  = 43;
    localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [5:0] {
        OP_ADC     = 6'd0,
        OP_AND     = 6'd1,
        OP_ASL_A   = 6'd2,
        OP_ASL_M   = 6'd3,
        OP_BCC     = 6'd4,
        OP_BCS     = 6'd5,
        OP_BEQ     = 6'd6,
        OP_BIT     = 6'd7,
        OP_BMI     = 6'd8,
        OP_BNE     = 6'd9,
        OP_BPL     = 6'd10,
        OP_BVC     = 6'd11,
        OP_BVS     = 6'd12,
        OP_CLC     = 6'd13,
        OP_CLD     = 6'd14,
        OP_CLI     = 6'd15,
        OP_CLV     = 6'd16,
        OP_CMP     = 6'd17,
        OP_CPX     = 6'd18,
        OP_CPY     = 6'd19,
        OP_DCP     = 6'd20,
        OP_DEC     = 6'd21,
        OP_DEX     = 6'd22,
        OP_DEY     = 6'd23,
        OP_EOR     = 6'd24,
        OP_INC     = 6'd25,
        OP_INX     = 6'd26,
        OP_INY     = 6'd27,
        OP_ISC     = 6'd28,
        OP_LAX     = 6'd29,
        OP_LDA     = 6'd30,
        OP_LDX     = 6'd31,
        OP_LDY     = 6'd32,
        OP_LSR_A   = 6'd33,
        OP_LSR_M   = 6'd34,
        OP_NOP     = 6'd35,
        OP_ORA     = 6'd36,
        OP_RLA     = 6'd37,
        OP_ROL_A   = 6'd38,
        OP_ROL_M   = 6'd39,
        OP_ROR_A   = 6'd40,
        OP_ROR_M   = 6'd41,
        OP_RRA     = 6'd42,
        OP_SAX     = 6'd43,
        OP_SBC     = 6'd44,
        OP_SEC     = 6'd45,
        OP_SED     = 6'd46,
        OP_SEI     = 6'd47,
        OP_SLO     = 6'd48,
        OP_SRE     = 6'd49,
        OP_STA     = 6'd50,
        OP_STX     = 6'd51,
        OP_STY     = 6'd52,
        OP_TAX     = 6'd53,
        OP_TAY     = 6'd54,
        OP_TXA     = 6'd55,
        OP_TYA     = 6'd56
    } op_t;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  status_in;
        logic [7:0]  index_y;
        logic [7:0]  index_x;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [5:0]  func;
    } in_item_t;

    typedef struct packed {
        logic        page_cross;
        logic        taken;
        logic [15:0] next_pc;
        logic [7:0]  status_out;
        logic [7:0]  new_acc;
        logic        result_valid;
        logic [7:0]  result;
    } out_item_t;

endpackage

FILE: hw/rtl/byte_alu_flags_branch.sv
// Execute stage of an 8-bit 6502-style CPU in binary mode. Each item carries an operation
// code, the operand byte, A, X, Y, status and PC; the block returns the write-back byte, the
// new A, the new status, the branch target with taken and page-cross flags. One item is
// accepted every cycle unless the input side stalls; its result goes from the input register
// through one pass of flag and adder logic into the result register. The input side stalls
// only while both registers hold items and the output is not taken. Unused operation codes
// behave as NOP.
module byte_alu_flags_branch (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // func, operand, acc, index_x, index_y, status_in, pc, zero pad
    input  logic [bafb_pkg::IN_BYTES*8-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // result, result_valid, new_acc, status_out, next_pc, taken, page_cross, zero pad
    output logic [bafb_pkg::OUT_BYTES*8-1:0]     m_axis_tdata
);
    import bafb_pkg::*;

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic      out_valid_reg;
    logic      out_ready;
    logic      in_ready;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign in_ready      = !in_valid_reg || out_ready;
    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
        begin
            in_reg <= in_item_t'(s_axis_tdata[IN_BITS-1:0]);
        end
        if (out_ready && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] v);
        logic [7:0] r;
        r        = st;
        r[FL_Z]  = (v == 8'h00);
        r[FL_N]  = v[7];
        return r;
    endfunction

    // {status, sum}
    function automatic logic [15:0] add_c(input logic [7:0] a, input logic [7:0] m,
                                         input logic [7:0] st);
        logic [8:0] sum;
        logic [7:0] r;
        sum     = {1'b0, a} + {1'b0, m} + {8'd0, st[FL_C]};
        r       = st;
        r[FL_C] = sum[8];
        r[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
        r       = set_nz(r, sum[7:0]);
        return {r, sum[7:0]};
    endfunction

    function automatic logic [7:0] compare(input logic [7:0] r, input logic [7:0] m,
                                           input logic [7:0] st);
        logic [8:0] diff;
        logic [7:0] s;
        diff    = {1'b0, r} - {1'b0, m};
        s       = st;
        s[FL_C] = ~diff[8];
        s[FL_Z] = (r == m);
        s[FL_N] = diff[7];
        return s;
    endfunction

    logic [7:0]  m;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  st;
    logic        c;
    logic [7:0]  res;
    logic [15:0] addst;
    logic        wb;
    logic        is_br;
    logic        cond;
    logic [15:0] base;
    logic [15:0] target;

    always_comb
    begin
        m     = in_reg.operand;
        a     = in_reg.acc;
        x     = in_reg.index_x;
        y     = in_reg.index_y;
        st    = in_reg.status_in;
        c     = in_reg.status_in[FL_C];
        res   = 8'h00;
        addst = 16'h0000;
        wb    = 1'b0;
        is_br = 1'b0;
        cond  = 1'b0;

        case (op_t'(in_reg.func))
            OP_ADC:
            begin
                addst = add_c(a, m, st);
                a = addst[7:0]; st = addst[15:8]; res = a; wb = 1'b1;
            end
            OP_AND:   begin a = a & m; st = set_nz(st, a); res = a; wb = 1'b1; end
            OP_ASL_A:
            begin
                st[FL_C] = a[7]; a = {a[6:0], 1'b0}; st = set_nz(st, a); res = a; wb = 1'b1;
            end
            OP_ASL_M:
            begin
                st[FL_C] = m[7]; res = {m[6:0], 1'b0}; st = set_nz(st, res); wb = 1'b1;
            end
            OP_BCC:   begin is_br = 1'b1; cond = !st[FL_C]; end
            OP_BCS:   begin is_br = 1'b1; cond = st[FL_C]; end
            OP_BEQ:   begin is_br = 1'b1; cond = st[FL_Z]; end
            OP_BIT:
            begin
                st[FL_Z] = ((a & m) == 8'h00); st[FL_V] = m[6]; st[FL_N] = m[7];
            end
            OP_BMI:   begin is_br = 1'b1; cond = st[FL_N]; end
            OP_BNE:   begin is_br = 1'b1; cond = !st[FL_Z]; end
            OP_BPL:   begin is_br = 1'b1; cond = !st[FL_N]; end
            OP_BVC:   begin is_br = 1'b1; cond = !st[FL_V]; end
            OP_BVS:   begin is_br = 1'b1; cond = st[FL_V]; end
            OP_CLC:   st[FL_C] = 1'b0;
            OP_CLD:   st[FL_D] = 1'b0;
            OP_CLI:   st[FL_I] = 1'b0;
            OP_CLV:   st[FL_V] = 1'b0;
            OP_CMP:   st = compare(a, m, st);
            OP_CPX:   st = compare(x, m, st);
            OP_CPY:   st = compare(y, m, st);
            OP_DCP:   begin res = m - 8'd1; st = compare(a, res, st); wb = 1'b1; end
            OP_DEC:   begin res = m - 8'd1; st = set_nz(st, res); wb = 1'b1; end
            OP_DEX:   begin res = x - 8'd1; st = set_nz(st, res); wb = 1'b1; end
            OP_DEY:   begin res = y - 8'd1; st = set_nz(st, res); wb = 1'b1; end
            OP_EOR:   begin a = a ^ m; st = set_nz(st, a); res = a; wb = 1'b1; end
            OP_INC:   begin res = m + 8'd1; st = set_nz(st, res); wb = 1'b1; end
            OP_INX:   begin res = x + 8'd1; st = set_nz(st, res); wb = 1'b1; end
            OP_INY:   begin res = y + 8'd1; st = set_nz(st, res); wb = 1'b1; end
            OP_ISC:
            begin
                res = m + 8'd1;
                addst = add_c(a, ~res, st);
                a = addst[7:0]; st = addst[15:8]; wb = 1'b1;
            end
            OP_LAX, OP_LDA:
            begin
                a = m; res = m; st = set_nz(st, m); wb = 1'b1;
            end
            OP_LDX, OP_LDY:
            begin
                res = m; st = set_nz(st, m); wb = 1'b1;
            end
            OP_LSR_A:
            begin
                st[FL_C] = a[0]; a = {1'b0, a[7:1]}; st = set_nz(st, a); res = a; wb = 1'b1;
            end
            OP_LSR_M:
            begin
                st[FL_C] = m[0]; res = {1'b0, m[7:1]}; st = set_nz(st, res); wb = 1'b1;
            end
            OP_ORA:   begin a = a | m; st = set_nz(st, a); res = a; wb = 1'b1; end
            OP_RLA:
            begin
                st[FL_C] = m[7]; res = {m[6:0], c}; a = a & res; st = set_nz(st, a);
                wb = 1'b1;
            end
            OP_ROL_A:
            begin
                st[FL_C] = a[7]; a = {a[6:0], c}; st = set_nz(st, a); res = a; wb = 1'b1;
            end
            OP_ROL_M:
            begin
                st[FL_C] = m[7]; res = {m[6:0], c}; st = set_nz(st, res); wb = 1'b1;
            end
            OP_ROR_A:
            begin
                st[FL_C] = a[0]; a = {c, a[7:1]}; st = set_nz(st, a); res = a; wb = 1'b1;
            end
            OP_ROR_M:
            begin
                st[FL_C] = m[0]; res = {c, m[7:1]}; st = set_nz(st, res); wb = 1'b1;
            end
            OP_RRA:
            begin
                st[FL_C] = m[0]; res = {c, m[7:1]};
                addst = add_c(a, res, st);
                a = addst[7:0]; st = addst[15:8]; wb = 1'b1;
            end
            OP_SAX:   begin res = a & x; wb = 1'b1; end
            OP_SBC:
            begin
                addst = add_c(a, ~m, st);
                a = addst[7:0]; st = addst[15:8]; res = a; wb = 1'b1;
            end
            OP_SEC:   st[FL_C] = 1'b1;
            OP_SED:   st[FL_D] = 1'b1;
            OP_SEI:   st[FL_I] = 1'b1;
            OP_SLO:
            begin
                st[FL_C] = m[7]; res = {m[6:0], 1'b0}; a = a | res; st = set_nz(st, a);
                wb = 1'b1;
            end
            OP_SRE:
            begin
                st[FL_C] = m[0]; res = {1'b0, m[7:1]}; a = a ^ res; st = set_nz(st, a);
                wb = 1'b1;
            end
            OP_STA:   begin res = a; wb = 1'b1; end
            OP_STX:   begin res = x; wb = 1'b1; end
            OP_STY:   begin res = y; wb = 1'b1; end
            OP_TAX, OP_TAY:
            begin
                res = a; st = set_nz(st, a); wb = 1'b1;
            end
            OP_TXA:   begin a = x; res = x; st = set_nz(st, x); wb = 1'b1; end
            OP_TYA:   begin a = y; res = y; st = set_nz(st, y); wb = 1'b1; end
            default:  ;
        endcase

        base   = in_reg.pc + 16'd2;
        target = base + {{8{m[7]}}, m};

        out_next.result       = wb ? res : 8'h00;
        out_next.result_valid = wb;
        out_next.new_acc      = a;
        out_next.status_out   = st;
        out_next.next_pc      = is_br ? target : 16'h0000;
        out_next.taken        = is_br && cond;
        out_next.page_cross   = is_br && cond && (target[15:8] != base[15:8]);
    end

    a_cross_needs_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.page_cross |-> out_reg.taken)
        else $error("page cross without taken branch");

    a_no_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.result_valid |-> out_reg.result == 8'h00)
        else $error("result nonzero without write-back");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled while pipeline has room");

    a_taken_has_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.taken |-> !out_reg.result_valid)
        else $error("taken branch with write-back");

endmodule

FILE: tb/sv/byte_alu_flags_branch_test.sv
`timescale 1ns / 100ps

module byte_alu_flags_branch_test;
    import bafb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam logic [5:0]  UNUSED_CODE  = 6'd63;

    class exec_scoreboard;
        out_item_t pending_outcomes[$];
        int unsigned errors = 0;

        function logic [7:0] set_nz(logic [7:0] st, logic [7:0] v);
            st[FL_Z] = (v == 8'h00);
            st[FL_N] = v[7];
            return st;
        endfunction

        // return {status, sum}
        function logic [15:0] add_carry(logic [7:0] x, logic [7:0] y, logic [7:0] st);
            logic [8:0] sum;
            sum = {1'b0, x} + {1'b0, y} + {8'h00, st[FL_C]};
            st[FL_C] = sum[8];
            st[FL_V] = ~(x[7] ^ y[7]) & (x[7] ^ sum[7]);
            st = set_nz(st, sum[7:0]);
            return {st, sum[7:0]};
        endfunction

        function logic [7:0] compare(logic [7:0] r, logic [7:0] m, logic [7:0] st);
            logic [7:0] diff;
            diff = r - m;
            st[FL_C] = (r >= m);
            st[FL_Z] = (r == m);
            st[FL_N] = diff[7];
            return st;
        endfunction

        function out_item_t execute(in_item_t it);
            out_item_t  r;
            logic [7:0] m;
            logic [7:0] a;
            logic [7:0] x;
            logic [7:0] y;
            logic [7:0] st;
            logic [7:0] res;
            logic [15:0] base;
            logic [15:0] target;
            logic       c;
            logic       wb;
            logic       is_br;
            logic       cond;
            m = it.operand;
            a = it.acc;
            x = it.index_x;
            y = it.index_y;
            st = it.status_in;
            c = st[FL_C];
            res = 8'h00;
            wb = 1'b1;
            is_br = 1'b0;
            cond = 1'b0;
            case (it.func)
                OP_ADC:   begin {st, a} = add_carry(a, m, st); res = a; end
                OP_AND:   begin a = a & m; st = set_nz(st, a); res = a; end
                OP_ASL_A: begin st[FL_C] = a[7]; a = a << 1; st = set_nz(st, a); res = a; end
                OP_ASL_M: begin st[FL_C] = m[7]; res = m << 1; st = set_nz(st, res); end
                OP_BCC:   begin is_br = 1'b1; cond = ~st[FL_C]; end
                OP_BCS:   begin is_br = 1'b1; cond = st[FL_C]; end
                OP_BEQ:   begin is_br = 1'b1; cond = st[FL_Z]; end
                OP_BIT:
                begin
                    wb = 1'b0;
                    st[FL_Z] = ((a & m) == 8'h00);
                    st[FL_V] = m[6];
                    st[FL_N] = m[7];
                end
                OP_BMI:   begin is_br = 1'b1; cond = st[FL_N]; end
                OP_BNE:   begin is_br = 1'b1; cond = ~st[FL_Z]; end
                OP_BPL:   begin is_br = 1'b1; cond = ~st[FL_N]; end
                OP_BVC:   begin is_br = 1'b1; cond = ~st[FL_V]; end
                OP_BVS:   begin is_br = 1'b1; cond = st[FL_V]; end
                OP_CLC:   begin wb = 1'b0; st[FL_C] = 1'b0; end
                OP_CLD:   begin wb = 1'b0; st[FL_D] = 1'b0; end
                OP_CLI:   begin wb = 1'b0; st[FL_I] = 1'b0; end
                OP_CLV:   begin wb = 1'b0; st[FL_V] = 1'b0; end
                OP_CMP:   begin wb = 1'b0; st = compare(a, m, st); end
                OP_CPX:   begin wb = 1'b0; st = compare(x, m, st); end
                OP_CPY:   begin wb = 1'b0; st = compare(y, m, st); end
                OP_DCP:   begin res = m - 8'd1; st = compare(a, res, st); end
                OP_DEC:   begin res = m - 8'd1; st = set_nz(st, res); end
                OP_DEX:   begin res = x - 8'd1; st = set_nz(st, res); end
                OP_DEY:   begin res = y - 8'd1; st = set_nz(st, res); end
                OP_EOR:   begin a = a ^ m; st = set_nz(st, a); res = a; end
                OP_INC:   begin res = m + 8'd1; st = set_nz(st, res); end
                OP_INX:   begin res = x + 8'd1; st = set_nz(st, res); end
                OP_INY:   begin res = y + 8'd1; st = set_nz(st, res); end
                OP_ISC:   begin res = m + 8'd1; {st, a} = add_carry(a, ~res, st); end
                OP_LAX:   begin a = m; res = m; st = set_nz(st, m); end
                OP_LDA:   begin a = m; res = m; st = set_nz(st, m); end
                OP_LDX:   begin res = m; st = set_nz(st, m); end
                OP_LDY:   begin res = m; st = set_nz(st, m); end
                OP_LSR_A: begin st[FL_C] = a[0]; a = a >> 1; st = set_nz(st, a); res = a; end
                OP_LSR_M: begin st[FL_C] = m[0]; res = m >> 1; st = set_nz(st, res); end
                OP_ORA:   begin a = a | m; st = set_nz(st, a); res = a; end
                OP_RLA:
                begin
                    st[FL_C] = m[7];
                    res = {m[6:0], c};
                    a = a & res;
                    st = set_nz(st, a);
                end
                OP_ROL_A:
                begin
                    st[FL_C] = a[7];
                    a = {a[6:0], c};
                    st = set_nz(st, a);
                    res = a;
                end
                OP_ROL_M: begin st[FL_C] = m[7]; res = {m[6:0], c}; st = set_nz(st, res); end
                OP_ROR_A:
                begin
                    st[FL_C] = a[0];
                    a = {c, a[7:1]};
                    st = set_nz(st, a);
                    res = a;
                end
                OP_ROR_M: begin st[FL_C] = m[0]; res = {c, m[7:1]}; st = set_nz(st, res); end
                OP_RRA:
                begin
                    st[FL_C] = m[0];
                    res = {c, m[7:1]};
                    {st, a} = add_carry(a, res, st);
                end
                OP_SAX:   res = a & x;
                OP_SBC:   begin {st, a} = add_carry(a, ~m, st); res = a; end
                OP_SEC:   begin wb = 1'b0; st[FL_C] = 1'b1; end
                OP_SED:   begin wb = 1'b0; st[FL_D] = 1'b1; end
                OP_SEI:   begin wb = 1'b0; st[FL_I] = 1'b1; end
                OP_SLO:
                begin
                    st[FL_C] = m[7];
                    res = m << 1;
                    a = a | res;
                    st = set_nz(st, a);
                end
                OP_SRE:
                begin
                    st[FL_C] = m[0];
                    res = m >> 1;
                    a = a ^ res;
                    st = set_nz(st, a);
                end
                OP_STA:   res = a;
                OP_STX:   res = x;
                OP_STY:   res = y;
                OP_TAX:   begin res = a; st = set_nz(st, a); end
                OP_TAY:   begin res = a; st = set_nz(st, a); end
                OP_TXA:   begin a = x; res = x; st = set_nz(st, x); end
                OP_TYA:   begin a = y; res = y; st = set_nz(st, y); end
                default:  wb = 1'b0;
            endcase
            if (is_br)
            begin
                wb = 1'b0;
            end
            base = it.pc + 16'd2;
            target = base + {{8{m[7]}}, m};
            r.result = wb ? res : 8'h00;
            r.result_valid = wb;
            r.new_acc = a;
            r.status_out = st;
            r.next_pc = is_br ? target : 16'h0000;
            r.taken = is_br & cond;
            r.page_cross = is_br & cond & (target[15:8] != base[15:8]);
            return r;
        endfunction

        function void log_instruction(in_item_t it);
            pending_outcomes.push_back(execute(it));
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("mismatch in %s: expected %h, got %h", field, want, got);
                end
            end
        endfunction

        function void check_outcome(out_item_t got);
            out_item_t want;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("unexpected result item %h", got);
                end
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("result", 16'(want.result), 16'(got.result));
            compare_field("result_valid", 16'(want.result_valid), 16'(got.result_valid));
            compare_field("new_acc", 16'(want.new_acc), 16'(got.new_acc));
            compare_field("status_out", 16'(want.status_out), 16'(got.status_out));
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("taken", 16'(want.taken), 16'(got.taken));
            compare_field("page_cross", 16'(want.page_cross), 16'(got.page_cross));
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_BYTES*8-1:0]    s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_BYTES*8-1:0]   m_axis_tdata;
    logic                     no_idle;
    int unsigned              quiet_cycles;

    exec_scoreboard sb = new();

    byte_alu_flags_branch DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] rand_pc();
        logic [15:0] pc;
        pc = 16'($urandom_range(65535));
        if ($urandom_range(3) == 0)
        begin
            pc[7:0] = 8'hF0 | 8'($urandom_range(15));
        end
        return pc;
    endfunction

    function automatic logic want_idle();
        return !no_idle && ($urandom_range(99) < 18);
    endfunction

    task automatic send_instruction(input in_item_t it);
        while (want_idle())
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= {$urandom, $urandom};
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_BYTES*8-IN_BITS){1'b0}}, it};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.log_instruction(it);
    endtask

    task automatic send_fields(input logic [5:0] func, input logic [7:0] operand,
                               input logic [7:0] acc, input logic [7:0] index_x,
                               input logic [7:0] index_y, input logic [7:0] status_in,
                               input logic [15:0] pc);
        in_item_t it;
        it.func = func;
        it.operand = operand;
        it.acc = acc;
        it.index_x = index_x;
        it.index_y = index_y;
        it.status_in = status_in;
        it.pc = pc;
        send_instruction(it);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_outcome(out_item_t'(m_axis_tdata[OUT_BITS-1:0]));
        end
        m_axis_tready <= no_idle || ($urandom_range(99) >= 18);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        in_item_t it;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        no_idle = 1'b0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(OP_ADC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_ADC, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_ADC, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'h01, 16'hFFFF);
        send_fields(OP_SBC, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 16'h0000);
        send_fields(OP_SBC, 8'h01, 8'h80, 8'h00, 8'h00, 8'h01, 16'h0000);
        send_fields(OP_ISC, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_DCP, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_fields(OP_RRA, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_RLA, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 16'h0000);
        send_fields(OP_SLO, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_SRE, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 16'h0000);
        send_fields(OP_LAX, 8'h80, 8'h12, 8'h34, 8'h56, 8'h00, 16'h0000);
        send_fields(OP_SAX, 8'h00, 8'hF0, 8'h3C, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_BIT, 8'hC0, 8'h3F, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_CMP, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_BCC, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_BCS, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 16'h1234);
        send_fields(OP_BNE, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 16'h00FD);
        send_fields(OP_BEQ, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 16'h00FD);
        send_fields(OP_BVS, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h40, 16'hFFFE);
        send_fields(OP_BPL, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFE);
        send_fields(UNUSED_CODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_fields(OP_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_fields(OP_ROR_A, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 16'h0000);
        send_fields(OP_INX, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 16'h0000);
        send_fields(OP_DEY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 150) && (i < 280);
            it.func = 6'($urandom_range(63));
            it.operand = rand_byte();
            it.acc = rand_byte();
            it.index_x = rand_byte();
            it.index_y = rand_byte();
            it.status_in = 8'($urandom_range(255));
            it.pc = rand_pc();
            send_instruction(it);
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/bafb_pkg.sv
hw/rtl/byte_alu_flags_branch.sv
tb/sv/byte_alu_flags_branch_test.sv
